@@ design/bwti_pkg.sv @@
// Package for the block inverse BWT unit: sizes, codes and the control
// structs shared by the sequencer, the count unit and the store unit.
// No dependencies.
package bwti_pkg;

  localparam int BLOCK_SIZE = 4096;
  localparam int ADDR_W     = $clog2(BLOCK_SIZE);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int NUM_VALUES = 256;
  localparam int VAL_W      = 8;
  localparam int PIDX_W     = 12;
  localparam int CMP_W      = (PIDX_W > LEN_W) ? PIDX_W : LEN_W;

  typedef logic [VAL_W-1:0]  byte_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0]  len_t;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_PULL = 1'b1;

  typedef enum logic [1:0] {
    ST_BYTE      = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_IDLE      = 2'd2
  } status_t;

  typedef struct packed {
    logic  clear;
    logic  rd_en;
    byte_t rd_addr;
    logic  wr_en;
    byte_t wr_addr;
    len_t  wr_data;
  } cnt_cmd_t;

  typedef struct packed {
    logic  bs_wr_en;
    addr_t bs_wr_addr;
    byte_t bs_wr_data;
    logic  bs_rd_en;
    addr_t bs_rd_addr;
    logic  sc_wr_en;
    addr_t sc_wr_addr;
    addr_t sc_wr_data;
    logic  sc_rd_en;
    addr_t sc_rd_addr;
  } store_cmd_t;

endpackage

@@ design/bwti_if.sv @@
// Channel interfaces of the block inverse BWT unit: request items in,
// result items out, each with valid/ready. Depends on bwti_pkg.
interface bwti_in_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [bwti_pkg::VAL_W-1:0]   data_byte;
  logic                         end_of_block;
  logic [bwti_pkg::PIDX_W-1:0]  start_row;

  modport source (output valid, req_type, data_byte, end_of_block, start_row,
                  input ready);
  modport sink   (input valid, req_type, data_byte, end_of_block, start_row,
                  output ready);
endinterface

interface bwti_out_if;
  logic                       valid;
  logic                       ready;
  logic [bwti_pkg::VAL_W-1:0] out_byte;
  logic                       out_last;
  logic [1:0]                 status;

  modport source (output valid, out_byte, out_last, status, input ready);
  modport sink   (input valid, out_byte, out_last, status, output ready);
endinterface

@@ design/bwt_block_inverse_unit.sv @@
// Top level of the block inverse BWT unit: sequencer, shared adder and
// result register. Depends on bwti_pkg, bwti_if, bwti_count_unit, bwti_store_unit.
//
// Inverse Burrows-Wheeler transform of blocks of up to 4096 bytes by LF
// mapping. Load items (req_type 0) are taken one at a time; a load reads
// the count of its byte, then writes it back plus one. The load with
// end_of_block closes the block: after the load come the index check, a
// read and a write per count to turn the 256 counts into start offsets, a
// byte read, a count read and a write of successor entry and count per
// block byte to thread the successor table, and a successor table read to
// fetch the walk start. A pull item (req_type 1) gives one result item,
// waiting while the output register is still held by an earlier item; a
// bad-index close gives its result item after the index check in the same
// way. All passes run through one adder and the single read and write
// ports of the count memory, byte store and successor table. ready is high
// only while the sequencer is idle; a result waits in the output register
// without blocking the next request.
module bwt_block_inverse_unit (
  input logic        clk,
  input logic        rst_n,
  bwti_in_if.sink    in_ch,
  bwti_out_if.source out_ch
);
  import bwti_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_CNT      = 11'b000_0000_0010,
    S_CLOSE    = 11'b000_0000_0100,
    S_PFX_RD   = 11'b000_0000_1000,
    S_PFX_WR   = 11'b000_0001_0000,
    S_THR_RD   = 11'b000_0010_0000,
    S_THR_SLOT = 11'b000_0100_0000,
    S_THR_WR   = 11'b000_1000_0000,
    S_WALK_RD  = 11'b001_0000_0000,
    S_WALK_SET = 11'b010_0000_0000,
    S_RESULT   = 11'b100_0000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic             open_r, open_nxt;
  len_t             len_r, len_nxt;
  len_t             left_r, left_nxt;
  addr_t            wp_r, wp_nxt;
  byte_t            v_r, v_nxt;
  addr_t            i_r, i_nxt;
  len_t             sum_r, sum_nxt;
  byte_t            byte_r, byte_nxt;
  logic             eob_r, eob_nxt;
  logic [CMP_W-1:0] pidx_r, pidx_nxt;
  status_t          kind_r, kind_nxt;
  logic             out_valid_r, out_valid_nxt;
  byte_t            out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  status_t          status_r, status_nxt;

  cnt_cmd_t   cnt_cmd;
  store_cmd_t st_cmd;
  len_t       cnt_value;
  byte_t      bs_rdata;
  addr_t      sc_rdata;
  len_t       add_a;
  len_t       add_res;
  len_t       len_cur;
  logic       in_acc;
  logic       slot_free;

  bwti_count_unit u_count (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cnt_cmd),
    .rd_value (cnt_value)
  );

  bwti_store_unit u_store (
    .clk      (clk),
    .cmd      (st_cmd),
    .bs_rdata (bs_rdata),
    .sc_rdata (sc_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign len_cur     = open_r ? len_r : '0;

  assign add_a   = (state_r == S_PFX_WR) ? sum_r : LEN_W'(1);
  assign add_res = add_a + cnt_value;

  always_comb begin
    state_nxt     = state_r;
    open_nxt      = open_r;
    len_nxt       = len_r;
    left_nxt      = left_r;
    wp_nxt        = wp_r;
    v_nxt         = v_r;
    i_nxt         = i_r;
    sum_nxt       = sum_r;
    byte_nxt      = byte_r;
    eob_nxt       = eob_r;
    pidx_nxt      = pidx_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    status_nxt    = status_r;
    cnt_cmd       = '0;
    st_cmd        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.req_type == REQ_LOAD) begin
            byte_nxt = in_ch.data_byte;
            eob_nxt  = in_ch.end_of_block;
            pidx_nxt = CMP_W'(in_ch.start_row);
            open_nxt = !in_ch.end_of_block;
            if (!open_r) begin
              cnt_cmd.clear = 1'b1;
              left_nxt      = '0;
            end
            if (len_cur < LEN_W'(BLOCK_SIZE)) begin
              st_cmd.bs_wr_en   = 1'b1;
              st_cmd.bs_wr_addr = ADDR_W'(len_cur);
              st_cmd.bs_wr_data = in_ch.data_byte;
              cnt_cmd.rd_en     = 1'b1;
              cnt_cmd.rd_addr   = in_ch.data_byte;
              len_nxt           = len_cur + LEN_W'(1);
              state_nxt         = S_CNT;
            end else begin
              len_nxt   = len_cur;
              state_nxt = in_ch.end_of_block ? S_CLOSE : S_IDLE;
            end
          end else begin
            if (left_r == '0) begin
              kind_nxt = ST_IDLE;
            end else begin
              kind_nxt          = ST_BYTE;
              st_cmd.bs_rd_en   = 1'b1;
              st_cmd.bs_rd_addr = wp_r;
              st_cmd.sc_rd_en   = 1'b1;
              st_cmd.sc_rd_addr = wp_r;
            end
            state_nxt = S_RESULT;
          end
        end
      end
      S_CNT: begin
        cnt_cmd.wr_en   = 1'b1;
        cnt_cmd.wr_addr = byte_r;
        cnt_cmd.wr_data = add_res;
        state_nxt       = eob_r ? S_CLOSE : S_IDLE;
      end
      S_CLOSE: begin
        if (pidx_r >= CMP_W'(len_r)) begin
          kind_nxt  = ST_BAD_INDEX;
          len_nxt   = '0;
          left_nxt  = '0;
          state_nxt = S_RESULT;
        end else begin
          v_nxt     = '0;
          sum_nxt   = '0;
          state_nxt = S_PFX_RD;
        end
      end
      S_PFX_RD: begin
        cnt_cmd.rd_en   = 1'b1;
        cnt_cmd.rd_addr = v_r;
        state_nxt       = S_PFX_WR;
      end
      S_PFX_WR: begin
        cnt_cmd.wr_en   = 1'b1;
        cnt_cmd.wr_addr = v_r;
        cnt_cmd.wr_data = sum_r;
        sum_nxt         = add_res;
        v_nxt           = v_r + VAL_W'(1);
        if (v_r == VAL_W'(NUM_VALUES - 1)) begin
          i_nxt     = '0;
          state_nxt = S_THR_RD;
        end else begin
          state_nxt = S_PFX_RD;
        end
      end
      S_THR_RD: begin
        st_cmd.bs_rd_en   = 1'b1;
        st_cmd.bs_rd_addr = i_r;
        state_nxt         = S_THR_SLOT;
      end
      S_THR_SLOT: begin
        cnt_cmd.rd_en   = 1'b1;
        cnt_cmd.rd_addr = bs_rdata;
        state_nxt       = S_THR_WR;
      end
      S_THR_WR: begin
        if (cnt_value < LEN_W'(BLOCK_SIZE)) begin
          st_cmd.sc_wr_en   = 1'b1;
          st_cmd.sc_wr_addr = ADDR_W'(cnt_value);
          st_cmd.sc_wr_data = i_r;
        end
        cnt_cmd.wr_en   = 1'b1;
        cnt_cmd.wr_addr = bs_rdata;
        cnt_cmd.wr_data = add_res;
        if (LEN_W'(i_r) == len_r - LEN_W'(1)) begin
          state_nxt = S_WALK_RD;
        end else begin
          i_nxt     = i_r + ADDR_W'(1);
          state_nxt = S_THR_RD;
        end
      end
      S_WALK_RD: begin
        st_cmd.sc_rd_en   = 1'b1;
        st_cmd.sc_rd_addr = ADDR_W'(pidx_r);
        state_nxt         = S_WALK_SET;
      end
      S_WALK_SET: begin
        wp_nxt    = sc_rdata;
        left_nxt  = len_r;
        state_nxt = S_IDLE;
      end
      S_RESULT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = kind_r;
          if (kind_r == ST_BYTE) begin
            out_byte_nxt = bs_rdata;
            out_last_nxt = (left_r == LEN_W'(1));
            wp_nxt       = sc_rdata;
            left_nxt     = left_r - LEN_W'(1);
          end else begin
            out_byte_nxt = '0;
            out_last_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      open_r      <= 1'b0;
      len_r       <= '0;
      left_r      <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      open_r      <= open_nxt;
      len_r       <= len_nxt;
      left_r      <= left_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    i_r        <= i_nxt;
    sum_r      <= sum_nxt;
    byte_r     <= byte_nxt;
    eob_r      <= eob_nxt;
    pidx_r     <= pidx_nxt;
    kind_r     <= kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    status_r   <= status_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;
  assign out_ch.status   = status_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(BLOCK_SIZE))
    else $error("block length beyond block size");

  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= len_r)
    else $error("pending byte count exceeds block length");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_THR_WR) |-> (cnt_value < len_r))
    else $error("threading slot outside block");

  a_pull_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.req_type == REQ_PULL) |=> (state_r == S_RESULT))
    else $error("pull item did not reach result stage");

  a_bad_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && kind_r == ST_BAD_INDEX) |-> (left_r == '0 && !open_r))
    else $error("bad index left a walk or an open block");

endmodule

@@ design/bwti_count_unit.sv @@
// Byte value count memory with per-entry valid bits; doubles as the
// next-slot table during threading. Depends on bwti_pkg.
module bwti_count_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  bwti_pkg::cnt_cmd_t cmd,
  output bwti_pkg::len_t     rd_value
);
  import bwti_pkg::*;

  len_t                  mem [NUM_VALUES];
  logic [NUM_VALUES-1:0] valid_r;
  len_t                  rdata_r;
  logic                  rvld_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[cmd.rd_addr];
      rvld_r  <= valid_r[cmd.rd_addr] & ~cmd.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clear) begin
      valid_r <= '0;
    end else if (cmd.wr_en) begin
      valid_r[cmd.wr_addr] <= 1'b1;
    end
  end

  assign rd_value = rvld_r ? rdata_r : '0;

endmodule

@@ design/bwti_store_unit.sv @@
// Block byte store and successor table, one write and one registered
// read port each. Depends on bwti_pkg.
module bwti_store_unit (
  input  logic                 clk,
  input  bwti_pkg::store_cmd_t cmd,
  output bwti_pkg::byte_t      bs_rdata,
  output bwti_pkg::addr_t      sc_rdata
);
  import bwti_pkg::*;

  byte_t bs_mem [BLOCK_SIZE];
  addr_t sc_mem [BLOCK_SIZE];
  byte_t bs_rdata_r;
  addr_t sc_rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.bs_wr_en) begin
      bs_mem[cmd.bs_wr_addr] <= cmd.bs_wr_data;
    end
    if (cmd.bs_rd_en) begin
      bs_rdata_r <= bs_mem[cmd.bs_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sc_wr_en) begin
      sc_mem[cmd.sc_wr_addr] <= cmd.sc_wr_data;
    end
    if (cmd.sc_rd_en) begin
      sc_rdata_r <= sc_mem[cmd.sc_rd_addr];
    end
  end

  assign bs_rdata = bs_rdata_r;
  assign sc_rdata = sc_rdata_r;

endmodule

@@ dv/tb_bwt_block_inverse_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for bwt_block_inverse_unit: random and directed load/pull
// items, with a built-in LF-mapping predictor that checks every result item.
// Depends on bwti_pkg, bwti_if and the unit under test.
module tb_bwt_block_inverse_unit;
  import bwti_pkg::*;

  localparam int TAIL_CYCLES = 13000;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_LEN    = 400;
  localparam int ITEM_TARGET = 1950;

  typedef struct packed {
    bit                hold_for_drain;
    logic              req_type;
    byte_t             data_byte;
    logic              end_of_block;
    logic [PIDX_W-1:0] start_row;
  } bwt_req_t;

  typedef struct packed {
    byte_t   data;
    logic    last;
    status_t status;
  } bwt_result_t;

  logic clk;
  logic rst_n = 1'b0;

  bwti_in_if  in_ch ();
  bwti_out_if out_ch ();

  bwt_block_inverse_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bwt_req_t    req_q[$];
  bwt_result_t expected_q[$];
  bwt_req_t    cur_req;
  bit          in_fire;
  int          n_taken;
  int          hold_left;
  bit          hold_done;
  bit          calm;
  int          n_errors;
  int          n_results;
  int          n_bytes;
  int          n_ends;
  int          n_bad;
  int          n_idle;

  // predictor state
  byte_t       blk_store [BLOCK_SIZE];
  addr_t       succ_tbl [BLOCK_SIZE];
  int unsigned val_count [NUM_VALUES] = '{default: 0};
  int unsigned blk_len = 0;
  addr_t       walk_ptr = '0;
  int unsigned bytes_left = 0;
  bit          blk_open = 1'b0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  assign calm = (n_taken >= 900) && (n_taken < 1200);

  function automatic void predict_walk(input bwt_req_t r);
    int unsigned next_slot [NUM_VALUES];
    int unsigned acc;
    int unsigned slot;
    bwt_result_t res;
    res = '{8'h00, 1'b0, ST_IDLE};
    if (r.req_type == REQ_LOAD) begin
      if (!blk_open) begin
        foreach (val_count[v]) val_count[v] = 0;
        blk_len    = 0;
        bytes_left = 0;
        blk_open   = 1'b1;
      end
      if (blk_len < BLOCK_SIZE) begin
        blk_store[blk_len] = r.data_byte;
        val_count[r.data_byte]++;
        blk_len++;
      end
      if (r.end_of_block) begin
        blk_open = 1'b0;
        if (r.start_row >= blk_len) begin
          blk_len    = 0;
          bytes_left = 0;
          res.status = ST_BAD_INDEX;
          expected_q.push_back(res);
        end else begin
          acc = 0;
          for (int v = 0; v < NUM_VALUES; v++) begin
            next_slot[v] = acc;
            acc += val_count[v];
          end
          for (int unsigned i = 0; i < blk_len; i++) begin
            slot = next_slot[blk_store[i]];
            succ_tbl[slot] = addr_t'(i);
            next_slot[blk_store[i]] = slot + 1;
          end
          walk_ptr   = succ_tbl[r.start_row];
          bytes_left = blk_len;
        end
      end
    end else begin
      if (bytes_left != 0) begin
        res.data   = blk_store[walk_ptr];
        walk_ptr   = succ_tbl[walk_ptr];
        bytes_left--;
        res.last   = (bytes_left == 0);
        res.status = ST_BYTE;
      end
      expected_q.push_back(res);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    if (n_errors <= 50)
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic add_item(input bit drain, input logic rt, input byte_t b, input logic eob,
                          input logic [PIDX_W-1:0] pidx);
    bwt_req_t it;
    it = '{drain, rt, b, eob, pidx};
    req_q.push_back(it);
  endtask

  task automatic add_block(input int len, input int pidx, input int npull, input int alpha,
                           input bit drain);
    byte_t base;
    byte_t b;
    base = byte_t'($urandom_range(255));
    for (int k = 0; k < len; k++) begin
      case (alpha)
        0:       b = byte_t'($urandom_range(255));
        1:       b = base + byte_t'($urandom_range(3));
        default: b = $urandom_range(1) ? 8'hFF : 8'h00;
      endcase
      add_item(drain && (k == 0), REQ_LOAD, b, k == len - 1,
               (k == len - 1) ? pidx[PIDX_W-1:0] : PIDX_W'($urandom));
    end
    repeat (npull)
      add_item(1'b0, REQ_PULL, byte_t'($urandom_range(255)), 1'($urandom_range(1)),
               PIDX_W'($urandom));
  endtask

  // driver
  always @(posedge clk) begin
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (in_fire) begin
      predict_walk(cur_req);
      n_taken++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (req_q.size() == 0 || (req_q[0].hold_for_drain && expected_q.size() != 0) ||
          (!calm && $urandom_range(99) < 28)) begin
        in_ch.valid <= 1'b0;
      end else begin
        cur_req = req_q.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.req_type      <= cur_req.req_type;
        in_ch.data_byte     <= cur_req.data_byte;
        in_ch.end_of_block  <= cur_req.end_of_block;
        in_ch.start_row     <= cur_req.start_row;
      end
    end
  end

  // receiver hold-off, counted in cycles
  always @(negedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (n_taken == HOLD_AT && !hold_done) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n || hold_left != 0)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= calm || ($urandom_range(99) >= 28);
  end

  // monitor
  always @(posedge clk) begin
    bwt_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result status", int'(out_ch.status), -1);
      end else begin
        want = expected_q.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", int'(out_ch.status), int'(want.status));
        if (out_ch.out_byte !== want.data)
          report_mismatch("out_byte", int'(out_ch.out_byte), int'(want.data));
        if (out_ch.out_last !== want.last)
          report_mismatch("out_last", int'(out_ch.out_last), int'(want.last));
        case (want.status)
          ST_BYTE: begin
            n_bytes++;
            if (want.last) n_ends++;
          end
          ST_BAD_INDEX: n_bad++;
          default:      n_idle++;
        endcase
      end
    end
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int n_items;
    int kind;
    int len;
    int npull;
    int pidx;
    bit first_random;
    int w;

    // directed: idle pull, single-byte blocks, bad indexes, full walks and a dropped walk
    add_item(1'b0, REQ_PULL, 8'h00, 1'b0, 12'h000);
    add_item(1'b0, REQ_LOAD, 8'hFF, 1'b1, 12'h000);
    add_item(1'b0, REQ_PULL, 8'h00, 1'b0, 12'h000);
    add_item(1'b0, REQ_PULL, 8'hFF, 1'b1, 12'hFFF);
    add_item(1'b0, REQ_LOAD, 8'h00, 1'b0, 12'hFFF);
    add_item(1'b0, REQ_LOAD, 8'h80, 1'b1, 12'd2);
    add_item(1'b0, REQ_PULL, 8'h00, 1'b0, 12'h000);
    add_item(1'b0, REQ_LOAD, 8'h55, 1'b1, 12'hFFF);
    add_item(1'b0, REQ_LOAD, "n", 1'b0, 12'h000);
    add_item(1'b0, REQ_LOAD, "n", 1'b0, 12'h000);
    add_item(1'b0, REQ_LOAD, "b", 1'b0, 12'h000);
    add_item(1'b0, REQ_LOAD, "a", 1'b0, 12'h000);
    add_item(1'b0, REQ_LOAD, "a", 1'b0, 12'h000);
    add_item(1'b0, REQ_LOAD, "a", 1'b1, 12'd3);
    repeat (7) add_item(1'b0, REQ_PULL, 8'h00, 1'b0, 12'h000);
    add_item(1'b0, REQ_LOAD, 8'hAA, 1'b0, 12'h000);
    add_item(1'b0, REQ_LOAD, 8'h01, 1'b0, 12'h000);
    add_item(1'b0, REQ_LOAD, 8'hAA, 1'b1, 12'd2);
    add_item(1'b0, REQ_PULL, 8'h00, 1'b0, 12'h000);
    add_item(1'b0, REQ_LOAD, 8'h7F, 1'b0, 12'h000);
    add_item(1'b0, REQ_LOAD, 8'h80, 1'b1, 12'd1);
    repeat (2) add_item(1'b0, REQ_PULL, 8'h00, 1'b0, 12'h000);

    n_items      = 0;
    first_random = 1'b1;
    while (n_items < ITEM_TARGET) begin
      kind = $urandom_range(99);
      len  = ($urandom_range(19) == 0) ? $urandom_range(300, 41) : $urandom_range(40, 1);
      if (kind < 78) begin
        pidx = $urandom_range(len - 1);
        case ($urandom_range(9))
          0:       npull = len + $urandom_range(3, 1);
          1:       npull = $urandom_range(len - 1);
          default: npull = len;
        endcase
        add_block(len, pidx, npull, $urandom_range(2), first_random || $urandom_range(29) == 0);
        n_items += len + npull;
      end else if (kind < 90) begin
        npull = $urandom_range(2);
        add_block(len, $urandom_range(4095, len), npull, $urandom_range(2), 1'b0);
        n_items += len + npull;
      end else begin
        npull = $urandom_range(10, 1);
        repeat (npull)
          add_item(1'b0, 1'($urandom_range(1)), byte_t'($urandom_range(255)),
                   $urandom_range(3) == 0, PIDX_W'($urandom));
        add_item(1'b0, REQ_LOAD, byte_t'($urandom_range(255)), 1'b1, PIDX_W'($urandom));
        n_items += npull + 1;
      end
      first_random = 1'b0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (req_q.size() != 0 || in_ch.valid) @(posedge clk);
    w = 0;
    while (expected_q.size() != 0 && w < TAIL_CYCLES) begin
      @(posedge clk);
      w++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    while (expected_q.size() != 0) begin
      report_mismatch("missing result, status", -1, int'(expected_q[0].status));
      void'(expected_q.pop_front());
    end

    $display("Sent %0d items; checked %0d results: %0d bytes closing %0d blocks,",
             n_taken, n_results, n_bytes, n_ends);
    $display("%0d bad-index closes, %0d idle pulls, a long output stall, drained restarts; %0d errors",
             n_bad, n_idle, n_errors);
    if (n_errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
